FILE: hdl/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
package uer_pkg;

    // event codes on the input kind field
    localparam logic [1:0] KIND_RISE = 2'd0;
    localparam logic [1:0] KIND_FALL = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // configuration register indexes
    localparam logic CFG_MIN_DELAY  = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    // field widths
    localparam int KIND_W     = 2;
    localparam int SUB_W      = 16;
    localparam int DELAY_W    = 10;
    localparam int CFG_W      = 16;
    localparam int MS_W_MAX   = 16;
    localparam int PULSE_W    = 20;
    localparam int DIST_W     = 19;
    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 16;
    localparam int RECIP_W    = 24;
    localparam int DIST_SHIFT = 25;

    // arithmetic constants
    localparam logic [PULSE_W-1:0]  PULSE_MAX = 20'hFFFFF;
    localparam logic [9:0]          SUB_SCALE = 10'd999;
    localparam logic [9:0]          MS_US     = 10'd1000;
    // width*16/58 as width*ceil(2^28/29) >> 25, exact for every 20-bit width
    localparam logic [RECIP_W-1:0]  DIST_RECIP = 24'd9256396;

    // measurement phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MEASURE = 2'd1,
        PH_HOLDOFF = 2'd2
    } t_phase;

    // back end sequencer state
    typedef enum logic [2:0] {
        BK_IDLE    = 3'd0,
        BK_START_Q = 3'd1,
        BK_WAIT_Q  = 3'd2,
        BK_SUM     = 3'd3,
        BK_DIST    = 3'd4,
        BK_OUT     = 3'd5
    } t_back_state;

    // classified event handed from front to back
    typedef struct packed {
        logic                 meas;
        logic                 trig;
        logic [MS_W_MAX-1:0]  ms;
        logic [SUB_W-1:0]     sub;
        logic [DIVISOR_W-1:0] fs;
    } t_cmd;

    // divider request
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    // divider status
    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: hdl/uer_front.sv
// front end: config registers, phase tracking and event classification
// depends on uer_pkg; pushes one command per accepted word into the queue
module uer_front #(
    parameter int MS_COUNT_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [uer_pkg::KIND_W-1:0] i_kind,
    input  logic [uer_pkg::SUB_W-1:0]  i_sub_count,
    input  logic                     i_full,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [uer_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                     o_push,
    output uer_pkg::t_cmd            o_cmd
);
    import uer_pkg::*;

    localparam logic [MS_COUNT_BITS-1:0] MS_MAX = {MS_COUNT_BITS{1'b1}};

    logic [DELAY_W-1:0]       r_min_delay;
    logic [DIVISOR_W-1:0]     r_fs;
    t_phase                   r_phase, n_phase;
    logic [MS_COUNT_BITS-1:0] r_ms, n_ms;

    logic                     accept;
    logic [MS_COUNT_BITS-1:0] ms_inc;
    logic                     reached_cur;
    logic                     reached_inc;

    assign accept = i_valid && !i_full;

    // saturating tick count and delay checks
    assign ms_inc      = (r_ms == MS_MAX) ? r_ms : r_ms + 1'b1;
    assign reached_cur = (MS_W_MAX'(r_ms) >= MS_W_MAX'(r_min_delay)) || (r_ms == MS_MAX);
    assign reached_inc = (MS_W_MAX'(ms_inc) >= MS_W_MAX'(r_min_delay)) || (ms_inc == MS_MAX);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay <= DELAY_W'(50);
            r_fs        <= DIVISOR_W'(1000);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_DELAY:  r_min_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_FULL_SCALE: r_fs        <= i_cfg_data[DIVISOR_W-1:0];
                default: ;
            endcase
        end
    end

    // phase and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ms    <= '0;
        end else begin
            r_phase <= n_phase;
            r_ms    <= n_ms;
        end
    end

    // next phase and count
    always_comb begin
        n_phase = r_phase;
        n_ms    = r_ms;
        if (accept) begin
            case (r_phase)
                PH_MEASURE: begin
                    if (i_kind == KIND_FALL) begin
                        n_phase = reached_cur ? PH_IDLE : PH_HOLDOFF;
                    end else if (i_kind == KIND_TICK) begin
                        n_ms = ms_inc;
                    end
                end
                PH_HOLDOFF: begin
                    if (i_kind == KIND_TICK) begin
                        n_ms = ms_inc;
                        if (reached_inc) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // idle, and the unused code acts as idle
                    if (i_kind == KIND_RISE) begin
                        n_ms    = '0;
                        n_phase = PH_MEASURE;
                    end
                end
            endcase
        end
    end

    // command to the back end
    always_comb begin
        o_push     = accept;
        o_cmd.meas = (r_phase == PH_MEASURE) && (i_kind == KIND_FALL);
        o_cmd.trig = ((r_phase == PH_MEASURE) && (i_kind == KIND_FALL) && reached_cur)
                  || ((r_phase == PH_HOLDOFF) && (i_kind == KIND_TICK) && reached_inc);
        o_cmd.ms   = MS_W_MAX'(r_ms);
        o_cmd.sub  = i_sub_count;
        // zero full scale counts as one
        o_cmd.fs   = (r_fs == '0) ? DIVISOR_W'(1) : r_fs;
    end

endmodule

FILE: hdl/uer_fifo.sv
// small command queue between front and back ends
// depends on uer_pkg for the command type
module uer_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uer_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output uer_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import uer_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/uer_div.sv
// restoring divider, one quotient bit per cycle
// depends on uer_pkg for the request and status structs
module uer_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uer_pkg::t_div_req i_req,
    output uer_pkg::t_div_rsp o_rsp
);
    import uer_pkg::*;

    localparam int NW = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [NW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // one trial subtraction
    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = (rem_sh >= {1'b0, r_div});

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_cnt <= NW'(DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: hdl/uer_back.sv
// back end: pulse width and distance arithmetic, result register
// depends on uer_pkg and uer_div
module uer_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  uer_pkg::t_cmd               i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_distance_valid,
    output logic [uer_pkg::PULSE_W-1:0] o_pulse_us,
    output logic [uer_pkg::DIST_W-1:0]  o_distance_q4,
    output logic                        o_trigger
);
    import uer_pkg::*;

    t_back_state           r_state, n_state;
    logic                  r_meas;
    logic                  r_trig;
    logic [DIVIDEND_W-1:0] r_prod_q;
    logic [DIVIDEND_W-1:0] r_prod_ms;
    logic [DIVISOR_W-1:0]  r_fs;
    logic [PULSE_W-1:0]    r_pulse;
    logic [DIST_W-1:0]     r_dist;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic [DIVIDEND_W:0]   sum;
    logic [PULSE_W+RECIP_W-1:0] dist_prod;

    uer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // whole milliseconds plus scaled sub count
    assign sum = {1'b0, r_prod_ms} + {1'b0, div_rsp.quot};

    // divide by 58 through the reciprocal
    assign dist_prod = (PULSE_W+RECIP_W)'(r_pulse) * (PULSE_W+RECIP_W)'(DIST_RECIP);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_head.meas ? BK_START_Q : BK_OUT;
                end
            end
            BK_START_Q: n_state = BK_WAIT_Q;
            BK_WAIT_Q:  if (div_rsp.done) n_state = BK_SUM;
            BK_SUM:     n_state = BK_DIST;
            BK_DIST:    n_state = BK_OUT;
            BK_OUT:     if (i_ready) n_state = BK_IDLE;
            default:    n_state = BK_IDLE;
        endcase
    end

    // outputs and divider requests
    always_comb begin
        o_pop            = (r_state == BK_IDLE) && !i_empty;
        o_valid          = (r_state == BK_OUT);
        div_req.start    = (r_state == BK_START_Q);
        div_req.dividend = r_prod_q;
        div_req.divisor  = r_fs;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    r_meas    <= i_head.meas;
                    r_trig    <= i_head.trig;
                    r_prod_q  <= DIVIDEND_W'(i_head.sub) * DIVIDEND_W'(SUB_SCALE);
                    r_prod_ms <= DIVIDEND_W'(i_head.ms) * DIVIDEND_W'(MS_US);
                    r_fs      <= i_head.fs;
                    r_pulse   <= '0;
                    r_dist    <= '0;
                end
            end
            BK_SUM: begin
                // saturate the width
                r_pulse <= (sum > (DIVIDEND_W+1)'(PULSE_MAX)) ? PULSE_MAX : sum[PULSE_W-1:0];
            end
            BK_DIST: begin
                r_dist <= dist_prod[DIST_SHIFT +: DIST_W];
            end
            default: ;
        endcase
    end

    assign o_distance_valid = r_meas;
    assign o_pulse_us       = r_pulse;
    assign o_distance_q4    = r_dist;
    assign o_trigger        = r_trig;

endmodule

FILE: hdl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger: front end, command queue, back end
// depends on uer_pkg, uer_front, uer_fifo, uer_back (with uer_div)
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_kind, i_sub_count
//   result    out        o_valid / i_ready    o_distance_valid, o_pulse_us,
//                                             o_distance_q4, o_trigger
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// the front end takes one word per cycle while the queue has room
// a rise, tick or ignored word only takes the back end through pop and present, plus output wait
// an echo fall takes the back end through pop, start, the bit-serial full-scale
// divide, sum, scale to distance and present
// synchronous active-low reset; no clearing pass, ready in the first cycle after reset
// a stalled result holds the back end, the queue absorbs FIFO_DEPTH words
module ultrasonic_echo_ranger #(
    parameter int MS_COUNT_BITS = 10,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [uer_pkg::KIND_W-1:0]  i_kind,
    input  logic [uer_pkg::SUB_W-1:0]   i_sub_count,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [uer_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_distance_valid,
    output logic [uer_pkg::PULSE_W-1:0] o_pulse_us,
    output logic [uer_pkg::DIST_W-1:0]  o_distance_q4,
    output logic                        o_trigger
);
    import uer_pkg::*;

    t_cmd push_cmd;
    t_cmd head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_ready = !full;

    uer_front #(
        .MS_COUNT_BITS (MS_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_sub_count (i_sub_count),
        .i_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    uer_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    uer_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_distance_valid (o_distance_valid),
        .o_pulse_us       (o_pulse_us),
        .o_distance_q4    (o_distance_q4),
        .o_trigger        (o_trigger)
    );

endmodule

FILE: hdl/uer_checker.sv
// port-level checks for the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg for field widths
module uer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic                        o_distance_valid,
    input  logic [uer_pkg::PULSE_W-1:0] o_pulse_us,
    input  logic [uer_pkg::DIST_W-1:0]  o_distance_q4,
    input  logic                        o_trigger
);
    import uer_pkg::*;

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_valid)
            && $stable(o_pulse_us) && $stable(o_distance_q4) && $stable(o_trigger))
        else $error("stalled result changed");

    // no measurement means zero width and distance
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_distance_valid |-> (o_pulse_us == '0) && (o_distance_q4 == '0))
        else $error("width or distance set without a measurement");

    // distance is the truncated width times 16 over 58
    a_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_distance_valid |->
            (25'(o_distance_q4) * 25'd58 <= 25'(o_pulse_us) * 25'd16)
            && (25'(o_pulse_us) * 25'd16 < (25'(o_distance_q4) + 25'd1) * 25'd58))
        else $error("distance does not match width");

endmodule

bind ultrasonic_echo_ranger uer_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_distance_valid (o_distance_valid),
    .o_pulse_us       (o_pulse_us),
    .o_distance_q4    (o_distance_q4),
    .o_trigger        (o_trigger)
);
